@@ design/modular_inverse_unit_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the modular inverse unit
// Shorthand for clocked implication checks with synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_UNIT_CORE_ASSERT_SVH
`define MODULAR_INVERSE_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define MIU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modular inverse assertion failed");

// next-cycle implication
`define MIU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modular inverse assertion failed");

`endif

@@ design/miu_pkg.sv @@
// ---------------------------------------------------------------------------
// miu_pkg
// Shared constants and handshake types of the modular inverse unit.
// ---------------------------------------------------------------------------
package miu_pkg;

  // default operand width
  localparam int WIDTH_DEF = 32;

  // configuration port
  localparam int          CFG_AW      = 3;
  localparam logic [31:0] MODULUS_RST = 32'd2;
  localparam logic        REG_MODULUS = 1'b0;

  // sequencer to divider
  typedef struct packed {
    logic start;
  } miu_div_req_t;

  // divider to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } miu_div_sts_t;

endpackage

@@ design/modular_inverse_unit_core.sv @@
// ---------------------------------------------------------------------------
// modular_inverse_unit_core
// Modular inverse by the iterative extended Euclidean algorithm.
// ---------------------------------------------------------------------------
// Returns operand^-1 mod N for the modulus N held in the configuration
// register (reset value 2), or inverse 0 with no_inverse set when
// gcd(operand, N) > 1, when the operand is 0 or when N is below 2. One
// operand is worked on at a time; in_ready is high only while the unit is
// idle. Each Euclid step runs one pass of the shared bit-serial divider:
// a check of the remainder, the divide itself and the update of the
// remainders and coefficients. The number of steps depends on the data and
// is at most about 1.44*WIDTH+2; an operand of 1 or an N below 2 needs no
// divide step at all.
// A finished result sits in the output register while the next operand is
// taken.
// ---------------------------------------------------------------------------
module modular_inverse_unit_core #(
  parameter int WIDTH = miu_pkg::WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // operand channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                in_operand,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                out_inverse,
  output logic                       out_no_inverse,
  // configuration port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [miu_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [31:0]        modulus_r, modulus_nxt;
  logic [WIDTH-1:0]   x_r, x_nxt;
  logic [WIDTH-1:0]   y_r, y_nxt;
  logic [WIDTH:0]     vx_r, vx_nxt;
  logic [WIDTH:0]     vy_r, vy_nxt;
  logic               fail_r, fail_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_inverse_r, out_inverse_nxt;
  logic               out_no_inverse_r, out_no_inverse_nxt;

  logic               cfg_wr;
  logic               cfg_sel_mod;
  logic               in_xfer;
  logic               out_free;
  logic [WIDTH-1:0]   n_w;
  logic [WIDTH-1:0]   fixed;

  miu_pkg::miu_div_req_t div_req;
  miu_pkg::miu_div_sts_t div_sts;
  logic [WIDTH-1:0]      div_rem;
  logic [WIDTH:0]        div_prod;

  // configuration register
  assign cfg_pready  = 1'b1;
  assign cfg_sel_mod = (cfg_paddr[miu_pkg::CFG_AW-1] == miu_pkg::REG_MODULUS);
  assign cfg_wr      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign modulus_nxt = (cfg_wr && cfg_sel_mod) ? cfg_pwdata : modulus_r;
  assign cfg_prdata  = cfg_sel_mod ? modulus_r : '0;

  // working modulus and final sign fix-up
  assign n_w   = WIDTH'(modulus_r);
  assign fixed = vy_r[WIDTH] ? (vy_r[WIDTH-1:0] + n_w) : vy_r[WIDTH-1:0];

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  // sequencer
  always_comb begin
    state_nxt          = state_r;
    x_nxt              = x_r;
    y_nxt              = y_r;
    vx_nxt             = vx_r;
    vy_nxt             = vy_r;
    fail_nxt           = fail_r;
    out_valid_nxt      = out_valid_r & ~out_ready;
    out_inverse_nxt    = out_inverse_r;
    out_no_inverse_nxt = out_no_inverse_r;
    div_req.start      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          x_nxt     = n_w;
          y_nxt     = WIDTH'(in_operand);
          vx_nxt    = '0;
          vy_nxt    = (WIDTH+1)'(1);
          fail_nxt  = ((n_w >> 1) == '0);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (fail_r || y_r == WIDTH'(1)) begin
          state_nxt = ST_FIN;
        end else if (y_r == '0) begin
          fail_nxt  = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        // (x, y) <= (y, x mod y); coefficient update vx - q*vy
        if (div_sts.done) begin
          x_nxt     = y_r;
          y_nxt     = div_rem;
          vx_nxt    = vy_r;
          vy_nxt    = vx_r - div_prod;
          state_nxt = ST_CHECK;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_inverse_nxt    = fail_r ? '0 : 32'(fixed);
          out_no_inverse_nxt = fail_r;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= miu_pkg::MODULUS_RST;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      modulus_r   <= modulus_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    x_r              <= x_nxt;
    y_r              <= y_nxt;
    vx_r             <= vx_nxt;
    vy_r             <= vy_nxt;
    out_inverse_r    <= out_inverse_nxt;
    out_no_inverse_r <= out_no_inverse_nxt;
  end

  miu_div #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (x_r),
    .divisor  (y_r),
    .coef     (vy_r),
    .sts      (div_sts),
    .rem      (div_rem),
    .prod     (div_prod)
  );

  assign out_valid      = out_valid_r;
  assign out_inverse    = out_inverse_r;
  assign out_no_inverse = out_no_inverse_r;

endmodule

@@ design/miu_div.sv @@
// ---------------------------------------------------------------------------
// miu_div
// Shared restoring divider, one quotient bit per cycle. Alongside the
// quotient it accumulates quotient * coef modulo 2^(WIDTH+1) by shift-add.
// ---------------------------------------------------------------------------
module miu_div #(
  parameter int WIDTH = miu_pkg::WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  miu_pkg::miu_div_req_t req,
  input  logic [WIDTH-1:0]     dividend,
  input  logic [WIDTH-1:0]     divisor,
  input  logic [WIDTH:0]       coef,
  output miu_pkg::miu_div_sts_t sts,
  output logic [WIDTH-1:0]     rem,
  output logic [WIDTH:0]       prod
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] dvd_r, dvd_nxt;
  logic [WIDTH-1:0] dsr_r, dsr_nxt;
  logic [WIDTH:0]   coef_r, coef_nxt;
  logic [WIDTH:0]   prod_r, prod_nxt;

  logic [WIDTH:0]   rem_sh;
  logic [WIDTH+1:0] diff;
  logic             qbit;
  logic [WIDTH:0]   prod_sh;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_r, dvd_r[WIDTH-1]};
    diff    = {1'b0, rem_sh} - {2'b00, dsr_r};
    qbit    = ~diff[WIDTH+1];
    prod_sh = {prod_r[WIDTH-1:0], 1'b0};
  end

  // sequencing of the steps
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    coef_nxt = coef_r;
    prod_nxt = prod_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(WIDTH);
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      coef_nxt = coef;
      prod_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = qbit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      dvd_nxt  = {dvd_r[WIDTH-2:0], 1'b0};
      prod_nxt = qbit ? (prod_sh + coef_r) : prod_sh;
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
    coef_r <= coef_nxt;
    prod_r <= prod_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign rem      = rem_r;
  assign prod     = prod_r;

endmodule

@@ design/miu_checker.sv @@
// ---------------------------------------------------------------------------
// miu_checker
// Port-level checks of the modular inverse unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "modular_inverse_unit_core_assert.svh"

module miu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_inverse,
  input logic        out_no_inverse
);

  // a failed inversion always reports zero
  `MIU_ASSERT_IMP(a_noinv_zero, clk, rst_n, out_valid && out_no_inverse, out_inverse == 32'd0)

  // an existing inverse is never zero
  `MIU_ASSERT_IMP(a_inv_nonzero, clk, rst_n, out_valid && !out_no_inverse, out_inverse != 32'd0)

  // the unit is busy right after taking an operand
  `MIU_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)

  // a result stays until its transfer
  `MIU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                  out_valid && $stable(out_inverse) && $stable(out_no_inverse))

endmodule

bind modular_inverse_unit_core miu_checker u_miu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_inverse    (out_inverse),
  .out_no_inverse (out_no_inverse)
);
